// File: design/bsa_pkg.sv
// Shared widths, codes and defaults for the bitmap slot allocator.
package bsa_pkg;

  // Bitmap geometry
  localparam int WORD_BITS     = 64;
  localparam int BIT_W         = 6;
  localparam int SLOTS_DEFAULT = 1024;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 10;
  localparam int CAP_W    = 11;
  localparam int ESIZE_W  = 16;
  localparam int OFFSET_W = 26;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Largest capacity the register can express
  localparam int CAP_MAX = (1 << CAP_W) - 1;

  // Register reset values
  localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(1024);
  localparam logic [ESIZE_W-1:0] ESIZE_RESET    = ESIZE_W'(1);

  // Request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_ESIZE    = 2'd1,
    REG_SPARE2   = 2'd2,
    REG_SPARE3   = 2'd3
  } cfg_reg_t;

endpackage

// File: design/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: sequencer, config registers and bitmap RAM.
// Usage:
//   A request (action, slot_index) is taken at a clock edge with start high
//   and busy low. Exactly one result follows: granted_slot, byte_offset,
//   status, slot_used and used_total are valid for the single cycle in which
//   done is high, and are taken at the edge that ends that cycle. The
//   receiver has no means to stall; the block never holds a result back.
//   Configuration goes through its own channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data); cfg_ready is always high and each transfer writes
//   the register at cfg_index. Write configuration only while idle.
// Sequence:
//   Free and query: one bitmap RAM read between accept and done.
//   Out-of-range, no-op and allocate with zero capacity go straight to the result stage.
//   Allocate: the start-point remainder is computed first, one quotient bit
//   a cycle by a restoring subtractor; then one bitmap word is read and
//   searched per cycle, W being the number of 64-bit words scanned, 1 to
//   ceil(capacity/64)+1. A new request is accepted in the cycle done is high.
// Reset: rst clears the counters and sets the configuration registers to
//   their reset values, then a clearing pass writes every bitmap word to zero, busy high.
module bitmap_slot_allocator #(
  parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [bsa_pkg::ACTION_W-1:0]  action,
  input  logic [bsa_pkg::INDEX_W-1:0]   slot_index,
  // result channel
  output logic                          done,
  output logic [bsa_pkg::INDEX_W-1:0]   granted_slot,
  output logic [bsa_pkg::OFFSET_W-1:0]  byte_offset,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic                          slot_used,
  output logic [bsa_pkg::CAP_W-1:0]     used_total,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsa_pkg::*;

  localparam int WORDS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAP_LIMIT  = (SLOTS > CAP_MAX) ? CAP_MAX : SLOTS;
  localparam int PTR_W      = CAP_W - BIT_W;
  localparam int HALF_W     = CAP_W - 1;
  localparam int PROD_W     = CAP_W + ESIZE_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_SCAN,
    S_LOOKUP,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [CAP_W-1:0]   capacity;
  logic [ESIZE_W-1:0] element_size;

  // Pool state and request context
  logic [CAP_W-1:0]  used_count;
  logic [CAP_W-1:0]  op_slot;
  status_t           op_status;
  logic              op_used;
  logic              op_offset_en;
  action_t           op_action;
  logic [AW-1:0]     clr_addr;

  // Remainder unit
  logic [CAP_W-1:0]  rem;
  logic [HALF_W-1:0] dividend;
  logic [3:0]        div_cnt;
  logic [CAP_W:0]    trial;
  logic [CAP_W-1:0]  rem_next;

  // Scan pipeline
  logic [PTR_W-1:0]     ptr;
  logic                 wrap;
  logic                 issue_live;
  logic                 chk_valid;
  logic                 chk_last;
  logic [PTR_W-1:0]     chk_word;
  logic [WORD_BITS-1:0] chk_mask;

  // Combinational helpers
  logic [CAP_W-1:0]     cap_e;
  logic [PTR_W-1:0]     last_w;
  logic [CAP_W-1:0]     lim;
  logic [BIT_W:0]       hi;
  logic [BIT_W-1:0]     lo;
  logic [WORD_BITS-1:0] issue_mask;
  logic                 last_issue;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BIT_W-1:0]     found_pos;
  logic                 cur_bit;
  logic [PROD_W-1:0]    product;

  // RAM ports
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign used_total = used_count;

  // Effective capacity and last bitmap word in use
  assign cap_e  = (capacity > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : capacity;
  assign last_w = PTR_W'((cap_e - CAP_W'(1)) >> BIT_W);

  // One restoring step of (used_count / 2) mod capacity
  assign trial    = {rem, dividend[HALF_W-1]};
  assign rem_next = (trial >= {1'b0, cap_e}) ? CAP_W'(trial - {1'b0, cap_e})
                                             : trial[CAP_W-1:0];

  // Mask of candidate bits in the word being issued
  always_comb begin
    lim = wrap ? rem : cap_e;
    if (ptr < lim[CAP_W-1:BIT_W]) begin
      hi = (BIT_W+1)'(WORD_BITS);
    end else if (ptr == lim[CAP_W-1:BIT_W]) begin
      hi = {1'b0, lim[BIT_W-1:0]};
    end else begin
      hi = '0;
    end
    lo = (!wrap && ptr == rem[CAP_W-1:BIT_W]) ? rem[BIT_W-1:0] : '0;
    issue_mask = ({WORD_BITS{1'b1}} << lo) & ~({WORD_BITS{1'b1}} << hi);
  end

  assign last_issue = wrap && (ptr == rem[CAP_W-1:BIT_W]);

  // Lowest free candidate bit of the word just read
  assign free_bits = ~ram_rd_data & chk_mask;
  always_comb begin
    found_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (free_bits[p]) begin
        found_pos = BIT_W'(p);
      end
    end
  end
  assign found = chk_valid && (free_bits != '0);

  assign cur_bit = ram_rd_data[op_slot[BIT_W-1:0]];

  // Offset multiplier, registered into the result
  assign product = {{ESIZE_W{1'b0}}, op_slot} * {{CAP_W{1'b0}}, element_size};

  // RAM control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(ptr);
    unique case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_IDLE: begin
        ram_rd_en   = start;
        ram_rd_addr = AW'(slot_index >> BIT_W);
      end
      S_SCAN: begin
        ram_rd_en   = issue_live;
        ram_wr_en   = found;
        ram_wr_addr = AW'(chk_word);
        ram_wr_data = ram_rd_data | (WORD_BITS'(1) << found_pos);
      end
      S_LOOKUP: begin
        ram_wr_en   = (op_action == ACT_FREE) && cur_bit;
        ram_wr_addr = AW'(op_slot >> BIT_W);
        ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << op_slot[BIT_W-1:0]);
      end
      S_DIVIDE, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAPACITY_RESET;
      element_size <= ESIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        REG_ESIZE:    element_size <= cfg_data[ESIZE_W-1:0];
        REG_SPARE2, REG_SPARE3: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      done       <= 1'b0;
      issue_live <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_action    <= action_t'(action);
            op_slot      <= CAP_W'(slot_index);
            op_status    <= ST_OK;
            op_used      <= 1'b0;
            op_offset_en <= 1'b0;
            priority if (action_t'(action) == ACT_ALLOC) begin
              op_slot <= '0;
              if (cap_e == '0) begin
                op_status <= ST_FULL;
                state     <= S_OUT;
              end else begin
                rem      <= '0;
                dividend <= used_count[CAP_W-1:1];
                div_cnt  <= 4'(HALF_W - 1);
                state    <= S_DIVIDE;
              end
            end else if (action_t'(action) == ACT_FREE ||
                         action_t'(action) == ACT_QUERY) begin
              if (CAP_W'(slot_index) >= cap_e) begin
                op_status <= ST_RANGE;
                state     <= S_OUT;
              end else begin
                state <= S_LOOKUP;
              end
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_DIVIDE: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          div_cnt  <= div_cnt - 4'd1;
          if (div_cnt == '0) begin
            ptr        <= rem_next[CAP_W-1:BIT_W];
            wrap       <= 1'b0;
            issue_live <= 1'b1;
            chk_valid  <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // issue side: next word address
          chk_valid <= issue_live;
          chk_word  <= ptr;
          chk_mask  <= issue_mask;
          chk_last  <= last_issue;
          if (last_issue) begin
            issue_live <= 1'b0;
          end else if (!wrap && ptr == last_w) begin
            ptr  <= '0;
            wrap <= 1'b1;
          end else begin
            ptr <= ptr + PTR_W'(1);
          end
          // check side: word read last cycle
          if (found) begin
            op_slot      <= {chk_word, found_pos};
            op_offset_en <= 1'b1;
            used_count   <= used_count + CAP_W'(1);
            issue_live   <= 1'b0;
            chk_valid    <= 1'b0;
            state        <= S_OUT;
          end else if (chk_valid && chk_last) begin
            op_status  <= ST_FULL;
            issue_live <= 1'b0;
            chk_valid  <= 1'b0;
            state      <= S_OUT;
          end
        end

        S_LOOKUP: begin
          op_offset_en <= 1'b1;
          if (op_action == ACT_FREE) begin
            if (cur_bit) begin
              used_count <= used_count - CAP_W'(1);
            end else begin
              op_status <= ST_NOT_USED;
            end
          end else begin
            op_used <= cur_bit;
          end
          state <= S_OUT;
        end

        S_OUT: begin
          done         <= 1'b1;
          granted_slot <= op_slot[INDEX_W-1:0];
          byte_offset  <= op_offset_en ? product[OFFSET_W-1:0] : '0;
          status       <= op_status;
          slot_used    <= op_used;
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Use bitmap
  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// File: design/bsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: test/bitmap_slot_allocator_test.sv
// Self-checking testbench for the bitmap slot allocator: scoreboard, drivers and watchdog.
module bitmap_slot_allocator_test;
  import bsa_pkg::*;

  localparam int NUM_WORDS   = SLOTS_DEFAULT / WORD_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP     = 50;
  localparam int ITEMS_PER_SETTING = 160;

  // One expected result
  typedef struct {
    logic [INDEX_W-1:0]  slot;
    logic [OFFSET_W-1:0] offset;
    status_t             status;
    logic                used;
    logic [CAP_W-1:0]    total;
  } grant_t;

  // Mirror of the pool state and a queue of expected grants
  class slot_scoreboard;
    bit [WORD_BITS-1:0] bitmap [NUM_WORDS];
    bit [CAP_W-1:0]     used_cnt;
    bit [CAP_W-1:0]     capacity;
    bit [ESIZE_W-1:0]   esize;
    grant_t             grant_q[$];
    int                 errors;

    function new();
      used_cnt = '0;
      capacity = CAPACITY_RESET;
      esize    = ESIZE_RESET;
      errors   = 0;
    endfunction

    function int eff_cap();
      return (capacity > SLOTS_DEFAULT) ? SLOTS_DEFAULT : int'(capacity);
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function logic [OFFSET_W-1:0] offset_of(int slot);
      return OFFSET_W'(slot * int'(esize));
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CAPACITY: capacity = data[CAP_W-1:0];
        REG_ESIZE:    esize = data[ESIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the mirror and queue its grant
    function void note_input(action_t act, logic [INDEX_W-1:0] idx);
      grant_t r;
      int     cap;
      int     first;
      int     cand;
      int     slot;
      bit     found;
      cap   = eff_cap();
      slot  = int'(idx);
      found = 1'b0;
      r.slot   = idx;
      r.offset = '0;
      r.status = ST_OK;
      r.used   = 1'b0;
      case (act)
        ACT_ALLOC: begin
          r.slot   = '0;
          r.status = ST_FULL;
          if (cap != 0) begin
            // upward search from half the used count, wrapping at capacity
            first = int'(used_cnt >> 1) % cap;
            for (int i = 0; i < cap && !found; i++) begin
              cand = (first + i) % cap;
              if (!bitmap[cand / WORD_BITS][cand % WORD_BITS]) begin
                bitmap[cand / WORD_BITS][cand % WORD_BITS] = 1'b1;
                used_cnt++;
                r.slot   = INDEX_W'(cand);
                r.offset = offset_of(cand);
                r.status = ST_OK;
                found    = 1'b1;
              end
            end
          end
        end
        ACT_FREE, ACT_QUERY: begin
          if (slot >= cap) begin
            r.status = ST_RANGE;
          end else begin
            r.offset = offset_of(slot);
            if (act == ACT_QUERY) begin
              r.used = bitmap[slot / WORD_BITS][slot % WORD_BITS];
            end else if (bitmap[slot / WORD_BITS][slot % WORD_BITS]) begin
              bitmap[slot / WORD_BITS][slot % WORD_BITS] = 1'b0;
              used_cnt--;
            end else begin
              r.status = ST_NOT_USED;
            end
          end
        end
        default: ;
      endcase
      r.total = used_cnt;
      grant_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expected grant
    function void check(logic [INDEX_W-1:0] slot, logic [OFFSET_W-1:0] offset,
                        logic [STATUS_W-1:0] st, logic used, logic [CAP_W-1:0] total);
      grant_t e;
      if (grant_q.size() == 0) begin
        $error("result with no request outstanding: granted_slot %0d", slot);
        errors++;
        return;
      end
      e = grant_q.pop_front();
      if (slot !== e.slot) begin
        $error("granted_slot: expected %0d, actual %0d", e.slot, slot);
        errors++;
      end
      if (offset !== e.offset) begin
        $error("byte_offset: expected %0d, actual %0d", e.offset, offset);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (used !== e.used) begin
        $error("slot_used: expected %0d, actual %0d", e.used, used);
        errors++;
      end
      if (total !== e.total) begin
        $error("used_total: expected %0d, actual %0d", e.total, total);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ACTION_W-1:0]   action;
  logic [INDEX_W-1:0]    slot_index;
  logic                  done;
  logic [INDEX_W-1:0]    granted_slot;
  logic [OFFSET_W-1:0]   byte_offset;
  logic [STATUS_W-1:0]   status;
  logic                  slot_used;
  logic [CAP_W-1:0]      used_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_scoreboard sb = new();
  int stall_cycles = 0;

  always #5 clk = ~clk;

  bitmap_slot_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .slot_index   (slot_index),
    .done         (done),
    .granted_slot (granted_slot),
    .byte_offset  (byte_offset),
    .status       (status),
    .slot_used    (slot_used),
    .used_total   (used_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done)
      sb.check(granted_slot, byte_offset, status, slot_used, used_total);
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request after a random gap; returns at the falling edge after its transfer
  task automatic send_item(input action_t act, input logic [INDEX_W-1:0] idx, input int pct);
    int gap;
    gap = 0;
    while (pct > 0 && $urandom_range(99) < pct && gap < MAX_GAP) begin
      start = 1'b0;
      @(negedge clk);
      gap++;
    end
    start      = 1'b1;
    action     = act;
    slot_index = idx;
    do @(posedge clk); while (busy);
    sb.note_input(act, idx);
    @(negedge clk);
  endtask

  // Let every outstanding grant arrive
  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] cap_data,
                            input logic [CFG_DATA_W-1:0] esize_data);
    wait_idle();
    write_reg(REG_CAPACITY, cap_data);
    write_reg(REG_ESIZE, esize_data);
  endtask

  // Random requests; frees mostly aim at taken slots so the pool fills and drains
  task automatic run_random(input int count, input int pct);
    action_t            act;
    logic [INDEX_W-1:0] idx;
    int                 cap;
    int                 roll;
    int                 j;
    bit                 hit;
    for (int n = 0; n < count; n++) begin
      cap  = sb.eff_cap();
      roll = $urandom_range(99);
      if (roll < 45)
        act = ACT_ALLOC;
      else if (roll < 75)
        act = ACT_FREE;
      else if (roll < 95)
        act = ACT_QUERY;
      else
        act = ACT_NOP;
      if (cap == 0 || $urandom_range(9) == 0) begin
        idx = INDEX_W'($urandom_range(SLOTS_DEFAULT - 1));
      end else begin
        idx = INDEX_W'($urandom_range(cap - 1));
        hit = 1'b0;
        if (act == ACT_FREE && $urandom_range(3) != 0) begin
          for (int k = 0; k < cap && !hit; k++) begin
            j = (int'(idx) + k) % cap;
            if (sb.bitmap[j / WORD_BITS][j % WORD_BITS]) begin
              idx = INDEX_W'(j);
              hit = 1'b1;
            end
          end
        end
      end
      send_item(act, idx, pct);
    end
  endtask

  initial begin
    int                 idle_pct [3];
    logic [CAP_W-1:0]   cap;
    logic [ESIZE_W-1:0] esize;
    idle_pct = '{34, 79, 0};
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACT_ALLOC;
    slot_index = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_CAPACITY;
    cfg_data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Unused register indexes must leave the pool alone
    write_reg(REG_SPARE2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE3, CFG_DATA_W'($urandom));

    // Single slot pool: grant, full, range checks, double free, no-op
    set_config(16'd1, 16'hFFFF);
    send_item(ACT_ALLOC, 10'd0, 0);
    send_item(ACT_ALLOC, 10'h3FF, 0);
    send_item(ACT_QUERY, 10'd0, 0);
    send_item(ACT_QUERY, 10'd1, 0);
    send_item(ACT_FREE, 10'h3FF, 0);
    send_item(ACT_FREE, 10'd0, 0);
    send_item(ACT_FREE, 10'd0, 0);
    send_item(ACT_NOP, 10'h3FF, 0);

    // Zero capacity: no slots at all
    set_config(16'd0, 16'd0);
    send_item(ACT_ALLOC, 10'd0, 0);
    send_item(ACT_QUERY, 10'd0, 0);
    send_item(ACT_FREE, 10'd0, 0);

    // Capacity beyond the pool clamps to the full pool; largest offsets
    set_config(16'hFFFF, 16'hFFFF);
    send_item(ACT_ALLOC, 10'd0, 0);
    send_item(ACT_ALLOC, 10'd0, 0);
    send_item(ACT_ALLOC, 10'd0, 0);
    send_item(ACT_QUERY, 10'h3FF, 0);
    send_item(ACT_FREE, 10'h3FF, 0);
    send_item(ACT_QUERY, 10'd2, 0);

    // Capacity dropped below taken slots: they stay counted but unreachable
    set_config(16'd1, 16'hFFFF);
    send_item(ACT_QUERY, 10'd2, 0);
    send_item(ACT_FREE, 10'd2, 0);
    send_item(ACT_ALLOC, 10'd0, 0);

    // Capacity restored, zero element size
    set_config(16'd1024, 16'd0);
    send_item(ACT_FREE, 10'd2, 0);
    send_item(ACT_NOP, 10'd0, 0);

    // Random phases over a spread of settings, state carried across them
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(7))
          0: cap = 11'd0;
          1: cap = 11'd1;
          2: cap = 11'h7FF;
          3: cap = 11'd1024;
          4: cap = CAP_W'($urandom_range(16, 2));
          5: cap = CAP_W'($urandom_range(128, 17));
          default: cap = CAP_W'($urandom_range(1024, 1));
        endcase
        case ($urandom_range(3))
          0: esize = 16'd0;
          1: esize = 16'd1;
          2: esize = 16'hFFFF;
          default: esize = ESIZE_W'($urandom);
        endcase
        // upper data bits are outside the capacity register
        set_config({5'($urandom_range(31)), cap}, esize);
        run_random(ITEMS_PER_SETTING, idle_pct[p]);
      end
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/bsa_pkg.sv
design/bsa_ram.sv
design/bitmap_slot_allocator.sv
test/bitmap_slot_allocator_test.sv
